[hdl/i2p_pkg.sv]
// Shared types, character constants and lookup functions for the
// infix-to-postfix converter. No dependencies; used by all but i2p_ram.
`timescale 1ns / 1ps
`default_nettype none

package i2p_pkg;

  // ASCII characters that the converter treats specially
  localparam logic [7:0] CH_LPAREN = 8'h28;  // '('
  localparam logic [7:0] CH_RPAREN = 8'h29;  // ')'
  localparam logic [7:0] CH_MUL    = 8'h2A;  // '*'
  localparam logic [7:0] CH_PLUS   = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
  localparam logic [7:0] CH_DIV    = 8'h2F;  // '/'
  localparam logic [7:0] CH_POW    = 8'h5E;  // '^'
  localparam logic [7:0] CH_SPACE  = 8'h20;  // ' '

  // Stack entry code
  typedef enum logic [2:0] {
    OPC_NONE   = 3'd0,
    OPC_LPAREN = 3'd1,
    OPC_PLUS   = 3'd2,
    OPC_MINUS  = 3'd3,
    OPC_MUL    = 3'd4,
    OPC_DIV    = 3'd5,
    OPC_POW    = 3'd6
  } op_code_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_UNMATCHED = 2'd1,
    ERR_FULL      = 2'd2
  } err_code_t;

  // What the latched input beat is
  typedef enum logic [2:0] {
    K_END,
    K_LPAREN,
    K_RPAREN,
    K_OP,
    K_SPACE,
    K_OPERAND
  } item_kind_t;

  // What goes into the output register
  typedef enum logic [2:0] {
    EM_TOP,
    EM_OPERAND,
    EM_MARKER,
    EM_ERR_PAREN,
    EM_ERR_FULL
  } emit_sel_t;

  typedef enum logic [0:0] {
    S_IDLE,
    S_EXEC
  } state_t;

  // Datapath -> controller
  typedef struct packed {
    item_kind_t kind;
    logic       empty;
    logic       has2;           // at least two entries stacked
    logic       full;
    logic       top_is_lp;
    logic       below_is_lp;
    logic       prec_le_top;    // incoming operator binds no tighter than top
    logic       prec_le_below;  // same, against the entry under the top
  } dp_status_t;

  // Controller -> datapath
  typedef struct packed {
    logic      load;
    logic      push;
    logic      pop;
    logic      emit;
    emit_sel_t emit_sel;
    logic      last;
  } dp_cmd_t;

  function automatic op_code_t char_to_code(input logic [7:0] c);
    op_code_t r;
    case (c)
      CH_LPAREN: r = OPC_LPAREN;
      CH_PLUS:   r = OPC_PLUS;
      CH_MINUS:  r = OPC_MINUS;
      CH_MUL:    r = OPC_MUL;
      CH_DIV:    r = OPC_DIV;
      CH_POW:    r = OPC_POW;
      default:   r = OPC_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] code_to_char(input op_code_t code);
    logic [7:0] r;
    case (code)
      OPC_LPAREN: r = CH_LPAREN;
      OPC_PLUS:   r = CH_PLUS;
      OPC_MINUS:  r = CH_MINUS;
      OPC_MUL:    r = CH_MUL;
      OPC_DIV:    r = CH_DIV;
      OPC_POW:    r = CH_POW;
      default:    r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] code_prec(input op_code_t code);
    logic [1:0] r;
    case (code)
      OPC_PLUS, OPC_MINUS: r = 2'd1;
      OPC_MUL, OPC_DIV:    r = 2'd2;
      OPC_POW:             r = 2'd3;
      default:             r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/i2p_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module i2p_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read (read-first)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/i2p_dp.sv]
// Datapath: input beat latch, operator stack (top in a register, the rest
// in i2p_ram), stack count and the output register. Uses i2p_pkg, i2p_ram.
`timescale 1ns / 1ps
`default_nettype none

module i2p_dp
  import i2p_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_cmd,
  input  wire logic [7:0] in_char,
  input  wire dp_cmd_t    cmd,
  output dp_status_t      status,
  output logic            out_free,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_char,
  output logic            has_char,
  output logic            expr_done,
  output err_code_t       error_code,
  output logic            run_last
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic            item_cmd;
  logic [7:0]      item_char;
  op_code_t        item_code;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  op_code_t        top;
  op_code_t        top_next;
  op_code_t        below;
  op_code_t        fwd_code;
  logic            wr_hit;
  logic [CW-1:0]   wr_cnt;
  logic [CW-1:0]   rd_cnt;
  logic [AW-1:0]   waddr;
  logic [AW-1:0]   raddr;
  logic            ram_we;
  logic [2:0]      ram_rdata;

  assign item_code = char_to_code(item_char);

  // latch the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_cmd  <= in_cmd;
      item_char <= in_char;
    end
  end

  // stack pointer and top-of-stack register
  always_comb begin
    count_next = count;
    top_next   = top;
    if (cmd.push) begin
      count_next = count + CW'(1);
      top_next   = item_code;
    end else if (cmd.pop) begin
      count_next = count - CW'(1);
      top_next   = below;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    top <= top_next;
  end

  // old top spills into the RAM on a push; the RAM always prefetches the
  // entry under the next top
  assign wr_cnt = count - CW'(1);
  assign rd_cnt = count_next - CW'(2);
  assign waddr  = wr_cnt[AW-1:0];
  assign raddr  = rd_cnt[AW-1:0];
  assign ram_we = cmd.push && (count != '0);

  i2p_ram #(
    .WIDTH (3),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (top),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // forward a same-address write, the RAM reads first
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_hit <= 1'b0;
    end else begin
      wr_hit <= ram_we && (waddr == raddr);
    end
  end

  always_ff @(posedge clk) begin
    fwd_code <= top;
  end

  assign below = wr_hit ? fwd_code : op_code_t'(ram_rdata);

  // classify the item and compare against the stack
  always_comb begin
    if (item_cmd) begin
      status.kind = K_END;
    end else if (item_code == OPC_LPAREN) begin
      status.kind = K_LPAREN;
    end else if (item_char == CH_RPAREN) begin
      status.kind = K_RPAREN;
    end else if (item_code != OPC_NONE) begin
      status.kind = K_OP;
    end else if (item_char == CH_SPACE) begin
      status.kind = K_SPACE;
    end else begin
      status.kind = K_OPERAND;
    end
    status.empty         = (count == '0);
    status.has2          = (count > CW'(1));
    status.full          = (count >= CW'(STACK_DEPTH));
    status.top_is_lp     = (top == OPC_LPAREN);
    status.below_is_lp   = (below == OPC_LPAREN);
    status.prec_le_top   = (code_prec(item_code) <= code_prec(top));
    status.prec_le_below = (code_prec(item_code) <= code_prec(below));
  end

  // output register
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      run_last <= cmd.last;
      case (cmd.emit_sel)
        EM_TOP: begin
          out_char   <= code_to_char(top);
          has_char   <= 1'b1;
          expr_done  <= 1'b0;
          error_code <= ERR_NONE;
        end
        EM_OPERAND: begin
          out_char   <= item_char;
          has_char   <= 1'b1;
          expr_done  <= 1'b0;
          error_code <= ERR_NONE;
        end
        EM_MARKER: begin
          out_char   <= 8'h00;
          has_char   <= 1'b0;
          expr_done  <= 1'b1;
          error_code <= ERR_NONE;
        end
        EM_ERR_PAREN: begin
          out_char   <= 8'h00;
          has_char   <= 1'b0;
          expr_done  <= 1'b0;
          error_code <= ERR_UNMATCHED;
        end
        default: begin
          out_char   <= 8'h00;
          has_char   <= 1'b0;
          expr_done  <= 1'b0;
          error_code <= ERR_FULL;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/i2p_ctrl.sv]
// Controller: takes one beat at a time, picks what the datapath emits and
// steps the stack one push or pop per cycle unless an emit waits. Uses i2p_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2p_ctrl
  import i2p_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t status,
  input  wire logic       out_free,
  output dp_cmd_t         cmd
);

  state_t  state;
  state_t  state_next;
  state_t  plan_state;
  dp_cmd_t plan;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    plan       = '0;
    plan_state = state;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          plan.load  = 1'b1;
          plan_state = S_EXEC;
        end
      end
      S_EXEC: begin
        case (status.kind)
          // flush: pop everything, then the marker
          K_END: begin
            plan.emit = 1'b1;
            if (!status.empty) begin
              plan.emit_sel = EM_TOP;
              plan.pop      = 1'b1;
            end else begin
              plan.emit_sel = EM_MARKER;
              plan.last     = 1'b1;
              plan_state    = S_IDLE;
            end
          end
          K_LPAREN: begin
            plan_state = S_IDLE;
            if (!status.full) begin
              plan.push = 1'b1;
            end else begin
              plan.emit     = 1'b1;
              plan.emit_sel = EM_ERR_FULL;
              plan.last     = 1'b1;
            end
          end
          // pop to the matching '(', last beat known one entry ahead
          K_RPAREN: begin
            if (status.empty) begin
              plan.emit     = 1'b1;
              plan.emit_sel = EM_ERR_PAREN;
              plan.last     = 1'b1;
              plan_state    = S_IDLE;
            end else if (status.top_is_lp) begin
              plan.pop   = 1'b1;
              plan_state = S_IDLE;
            end else begin
              plan.emit     = 1'b1;
              plan.emit_sel = EM_TOP;
              plan.pop      = 1'b1;
              plan.last     = status.has2 && status.below_is_lp;
            end
          end
          // pop operators of equal or higher precedence, then push (or flag full)
          K_OP: begin
            if (!status.empty && status.prec_le_top) begin
              plan.emit     = 1'b1;
              plan.emit_sel = EM_TOP;
              plan.pop      = 1'b1;
              plan.last     = !(status.has2 && status.prec_le_below);
            end else if (!status.full) begin
              plan.push  = 1'b1;
              plan_state = S_IDLE;
            end else begin
              plan.emit     = 1'b1;
              plan.emit_sel = EM_ERR_FULL;
              plan.last     = 1'b1;
              plan_state    = S_IDLE;
            end
          end
          K_SPACE: begin
            plan_state = S_IDLE;
          end
          default: begin
            plan.emit     = 1'b1;
            plan.emit_sel = EM_OPERAND;
            plan.last     = 1'b1;
            plan_state    = S_IDLE;
          end
        endcase
      end
      default: begin
        plan_state = S_IDLE;
      end
    endcase

    // hold everything while a result cannot be written
    if (plan.emit && !out_free) begin
      cmd        = '0;
      state_next = state;
    end else begin
      cmd        = plan;
      state_next = plan_state;
    end
  end

endmodule

`default_nettype wire

[hdl/infix_to_postfix_converter_top.sv]
// Top level of the infix-to-postfix converter: stream ports, controller
// and datapath. Uses i2p_pkg, i2p_ctrl, i2p_dp.
`timescale 1ns / 1ps
`default_nettype none

// Shunting-yard converter. One infix character (or an end command) enters
// per slave beat; postfix characters, error beats and the end-of-expression
// marker leave on the master side, with tlast on the final beat an input
// beat causes (a space, a plain push or a ')' that meets its '(' causes
// none). Operators are held on a STACK_DEPTH-entry stack, the top in a
// register and the rest in a RAM that always prefetches the entry below the
// top. An item is accepted in S_IDLE and handled in S_EXEC, which pops one
// operator at a time, holds while the master side stalls and accepts no new
// item until it is done. The stack needs no clearing after reset.
module infix_to_postfix_converter_top
  import i2p_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] in_char
  input  wire logic [0:0] s_tuser,   // [0] cmd
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_char
  output logic [3:0]      m_tuser,   // [0] has_char, [1] expr_done, [3:2] error_code
  output logic            m_tlast    // run_last
);

  dp_status_t status;
  dp_cmd_t    cmd;
  logic       out_free;
  logic       has_char;
  logic       expr_done;
  err_code_t  error_code;

  i2p_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .out_free (out_free),
    .cmd      (cmd)
  );

  i2p_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_cmd     (s_tuser[0]),
    .in_char    (s_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_free   (out_free),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_char   (m_tdata),
    .has_char   (has_char),
    .expr_done  (expr_done),
    .error_code (error_code),
    .run_last   (m_tlast)
  );

  assign m_tuser = {error_code, expr_done, has_char};

  // a result is only written into a free output register
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("result written over an unread beat");

  // stack never underflows
  assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !status.empty)
    else $error("pop from empty stack");

  // stack never overflows
  assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !status.full)
    else $error("push onto full stack");

  // one item at a time: no accept right after an accept
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second beat accepted while an item is in progress");

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for infix_to_postfix_converter_top: directed table,
// then random expressions, checked against an in-bench shunting-yard model.
// Depends on i2p_pkg and the converter RTL only.
`timescale 1ns / 1ps

module testbench;
  import i2p_pkg::*;

  localparam int STACK_DEPTH = 32;
  localparam int N_DIRECTED  = 25;
  localparam int ITEM_TARGET = 280;

  // One expected output beat
  typedef struct packed {
    logic [7:0] ch;
    logic       has;
    logic       done;
    err_code_t  err;
    logic       last;
  } postfix_beat_t;

  // How a table row is checked
  typedef enum logic [1:0] {
    CHK_MODEL,  // predicted by the shadow stack
    CHK_NONE,   // typed: causes no output beat
    CHK_ONE     // typed: exactly the beat in want
  } row_check_t;

  typedef struct packed {
    logic          is_end;
    logic [7:0]    ch;
    row_check_t    chk;
    postfix_beat_t want;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;  // [7:0] in_char
  logic [0:0] s_tuser = 1'b0;   // [0] cmd
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;          // [7:0] out_char
  logic [3:0] m_tuser;          // [0] has_char, [1] expr_done, [3:2] error_code
  logic       m_tlast;

  infix_to_postfix_converter_top #(.STACK_DEPTH(STACK_DEPTH)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow operator stack, holding the stacked characters themselves
  logic [7:0]    op_shadow [STACK_DEPTH];
  int            op_depth = 0;
  postfix_beat_t postfix_due [$];
  dir_row_t      seq [$];
  bit            burst = 1'b0;
  int            fails = 0;
  int            items_in = 0;
  int            real_items = 0;
  int            beats_seen = 0;
  int            markers = 0;
  int            paren_errs = 0;
  int            full_errs = 0;

  function automatic postfix_beat_t mk_beat(logic [7:0] c, logic has, logic done,
                                            err_code_t err);
    postfix_beat_t b;
    b.ch   = c;
    b.has  = has;
    b.done = done;
    b.err  = err;
    b.last = 1'b0;
    return b;
  endfunction

  function automatic dir_row_t step(logic is_end, logic [7:0] c);
    dir_row_t r;
    r.is_end = is_end;
    r.ch     = c;
    r.chk    = CHK_MODEL;
    r.want   = '0;
    return r;
  endfunction

  function automatic dir_row_t quiet(logic is_end, logic [7:0] c);
    dir_row_t r;
    r     = step(is_end, c);
    r.chk = CHK_NONE;
    return r;
  endfunction

  function automatic dir_row_t lone(logic is_end, logic [7:0] c, logic [7:0] oc,
                                    logic has, logic done, err_code_t err);
    dir_row_t r;
    r           = step(is_end, c);
    r.chk       = CHK_ONE;
    r.want      = mk_beat(oc, has, done, err);
    r.want.last = 1'b1;
    return r;
  endfunction

  // Binding strength; '(' and anything else rank 0
  function automatic int op_rank(logic [7:0] c);
    case (c)
      CH_POW:          return 3;
      CH_MUL, CH_DIV:  return 2;
      CH_PLUS, CH_MINUS: return 1;
      default:         return 0;
    endcase
  endfunction

  function automatic bit is_special(logic [7:0] c);
    case (c)
      CH_LPAREN, CH_RPAREN, CH_PLUS, CH_MINUS, CH_MUL, CH_DIV, CH_POW, CH_SPACE:
        return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Shunting-yard step on the shadow stack; record queues the beats it causes
  function automatic void shunt_char(logic is_end, logic [7:0] c, bit record);
    postfix_beat_t made [$];
    logic          found;
    logic [7:0]    top;
    found = 1'b0;
    if (is_end) begin
      while (op_depth != 0) begin
        op_depth--;
        made.push_back(mk_beat(op_shadow[op_depth], 1'b1, 1'b0, ERR_NONE));
      end
      made.push_back(mk_beat(8'h00, 1'b0, 1'b1, ERR_NONE));
    end else begin
      case (c)
        CH_RPAREN: begin
          while (op_depth != 0 && !found) begin
            op_depth--;
            top = op_shadow[op_depth];
            if (top == CH_LPAREN) found = 1'b1;
            else made.push_back(mk_beat(top, 1'b1, 1'b0, ERR_NONE));
          end
          if (!found) made.push_back(mk_beat(8'h00, 1'b0, 1'b0, ERR_UNMATCHED));
        end
        CH_LPAREN, CH_PLUS, CH_MINUS, CH_MUL, CH_DIV, CH_POW: begin
          // operators pop everything binding at least as tightly; '(' pops nothing
          while (c != CH_LPAREN && op_depth != 0 &&
                 op_rank(c) <= op_rank(op_shadow[op_depth-1])) begin
            op_depth--;
            made.push_back(mk_beat(op_shadow[op_depth], 1'b1, 1'b0, ERR_NONE));
          end
          if (op_depth >= STACK_DEPTH) begin
            made.push_back(mk_beat(8'h00, 1'b0, 1'b0, ERR_FULL));
          end else begin
            op_shadow[op_depth] = c;
            op_depth++;
          end
        end
        CH_SPACE: ;
        default: made.push_back(mk_beat(c, 1'b1, 1'b0, ERR_NONE));
      endcase
    end
    if (made.size() != 0) made[made.size()-1].last = 1'b1;
    if (record) foreach (made[i]) postfix_due.push_back(made[i]);
  endfunction

  // Directed table: edge cases after reset, then a mixed expression
  dir_row_t directed_rows [N_DIRECTED] = '{
    lone(1'b0, CH_RPAREN, 8'h00, 1'b0, 1'b0, ERR_UNMATCHED),  // ')' on empty stack
    lone(1'b1, 8'hFF,     8'h00, 1'b0, 1'b1, ERR_NONE),       // end, in_char ignored
    lone(1'b0, 8'h00,     8'h00, 1'b1, 1'b0, ERR_NONE),       // NUL is an operand
    lone(1'b0, 8'hFF,     8'hFF, 1'b1, 1'b0, ERR_NONE),
    quiet(1'b0, CH_SPACE),
    quiet(1'b0, CH_LPAREN),
    quiet(1'b0, CH_RPAREN),                                   // empty parentheses
    step(1'b0, "a"), step(1'b0, CH_PLUS), step(1'b0, "b"), step(1'b0, CH_MUL),
    step(1'b0, "c"), step(1'b0, CH_POW),  step(1'b0, "d"), step(1'b0, CH_POW),
    step(1'b0, "e"), step(1'b0, CH_MINUS), step(1'b0, CH_LPAREN), step(1'b0, "f"),
    step(1'b0, CH_DIV), step(1'b0, "g"), step(1'b0, CH_RPAREN),
    step(1'b0, CH_LPAREN), step(1'b0, "h"),                   // '(' left for the flush
    step(1'b1, 8'h00)
  };

  function automatic int pick_gap();
    return burst ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic logic [7:0] rand_operand();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_special(c));
    return c;
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 4))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_MUL;
      3:       return CH_DIV;
      default: return CH_POW;
    endcase
  endfunction

  function automatic logic [7:0] pick_special();
    case ($urandom_range(0, 3))
      0:       return CH_LPAREN;
      1:       return CH_RPAREN;
      2:       return CH_SPACE;
      default: return pick_op();
    endcase
  endfunction

  // Character beat, now and then preceded by a space
  function automatic void add_char(logic [7:0] c);
    if ($urandom_range(0, 9) == 0) seq.push_back(step(1'b0, CH_SPACE));
    seq.push_back(step(1'b0, c));
  endfunction

  // Well-formed expression with random operands, nesting and operators
  function automatic void build_expr();
    int n_opnd;
    int depth;
    n_opnd = $urandom_range(1, 8);
    depth  = 0;
    for (int i = 0; i < n_opnd; i++) begin
      while (depth < 6 && $urandom_range(0, 3) == 0) begin
        add_char(CH_LPAREN);
        depth++;
      end
      add_char(rand_operand());
      while (depth > 0 && $urandom_range(0, 2) == 0) begin
        add_char(CH_RPAREN);
        depth--;
      end
      if (i < n_opnd - 1) add_char(pick_op());
    end
    // sometimes leave open parentheses for the flush
    if ($urandom_range(0, 3) != 0) repeat (depth) add_char(CH_RPAREN);
    seq.push_back(step(1'b1, 8'($urandom_range(0, 255))));
  endfunction

  // Nesting close to, at or past a full stack
  function automatic void build_deep();
    int n;
    n = $urandom_range(STACK_DEPTH - 3, STACK_DEPTH + 4);
    repeat (n) begin
      seq.push_back(step(1'b0, CH_LPAREN));
      if ($urandom_range(0, 2) == 0) begin
        seq.push_back(step(1'b0, rand_operand()));
        seq.push_back(step(1'b0, pick_op()));
      end
    end
    repeat ($urandom_range(0, 5)) seq.push_back(step(1'b0, CH_RPAREN));
    seq.push_back(step(1'b1, 8'($urandom_range(0, 255))));
  endfunction

  // Broken input: stray brackets, operators, bytes and end commands
  function automatic void build_noise();
    int r;
    repeat ($urandom_range(1, 12)) begin
      r = $urandom_range(0, 9);
      if (r == 0)     seq.push_back(step(1'b1, 8'($urandom_range(0, 255))));
      else if (r < 5) seq.push_back(step(1'b0, pick_special()));
      else            seq.push_back(step(1'b0, 8'($urandom_range(0, 255))));
    end
  endfunction

  // Offer one input beat and note the expectations once it is taken
  task automatic drive_beat(dir_row_t row);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= row.ch;
    s_tuser  <= row.is_end;
    do @(posedge clk); while (!s_tready);
    items_in++;
    if (row.is_end || row.ch != CH_SPACE) real_items++;
    shunt_char(row.is_end, row.ch, row.chk == CHK_MODEL);
    if (row.chk == CHK_ONE) postfix_due.push_back(row.want);
  endtask

  // Withdraw the input and wait until every expected beat has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (postfix_due.size() != 0) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) drive_beat(directed_rows[i]);
    wait_drained();

    // first random sequence nests close to or past a full stack
    build_deep();
    while (real_items < ITEM_TARGET) begin
      burst = ($urandom_range(0, 4) == 0);
      while (seq.size() != 0) drive_beat(seq.pop_front());
      case ($urandom_range(0, 9))
        7, 8: build_noise();
        9: begin
          wait_drained();
          build_deep();
        end
        default: build_expr();
      endcase
    end

    wait_drained();
    repeat (2 * STACK_DEPTH + 8) @(posedge clk);
    $display("Covered %0d input beats and %0d output beats,", items_in, beats_seen);
    $display("with %0d end markers, %0d unmatched-paren and %0d stack-full errors.",
             markers, paren_errs, full_errs);
    if (fails == 0 && postfix_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Output side: random stalls and field-by-field comparison
  initial begin
    int            gap;
    postfix_beat_t want;
    err_code_t     got_err;
    wait (rst == 1'b0);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      beats_seen++;
      got_err = err_code_t'(m_tuser[3:2]);
      if (m_tuser[1]) markers++;
      if (got_err == ERR_UNMATCHED) paren_errs++;
      if (got_err == ERR_FULL) full_errs++;
      if (postfix_due.size() == 0) begin
        $error("unexpected output beat: out_char %h tuser %h tlast %b",
               m_tdata, m_tuser, m_tlast);
        fails++;
      end else begin
        want = postfix_due.pop_front();
        if (m_tdata !== want.ch) begin
          $error("out_char: expected %h, got %h", want.ch, m_tdata);
          fails++;
        end
        if (m_tuser[0] !== want.has) begin
          $error("has_char: expected %b, got %b", want.has, m_tuser[0]);
          fails++;
        end
        if (m_tuser[1] !== want.done) begin
          $error("expr_done: expected %b, got %b", want.done, m_tuser[1]);
          fails++;
        end
        if (m_tuser[3:2] !== want.err) begin
          $error("error_code: expected %0d, got %0d", want.err, m_tuser[3:2]);
          fails++;
        end
        if (m_tlast !== want.last) begin
          $error("run_last: expected %b, got %b", want.last, m_tlast);
          fails++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[files.f]
hdl/i2p_pkg.sv
hdl/i2p_ram.sv
hdl/i2p_dp.sv
hdl/i2p_ctrl.sv
hdl/infix_to_postfix_converter_top.sv
tb/sv/testbench.sv
